// ----- sv/ntwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ntwa_pkg
// types and constants shared by the neighbor table with aging
// ----------------------------------------------------------------------------
package ntwa_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEST_ID    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOD_ID    = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [15:0] AGE_LIMIT_RST = 16'd64;
    localparam logic [7:0]  NODE_TYPE_RST = 8'd2;
    localparam logic [15:0] NEST_ID_RST   = 16'd0;
    localparam logic [15:0] FOOD_ID_RST   = 16'd1;

    // start value of the nearest distance search
    localparam logic [6:0] NEAREST_START = 7'd90;

    // one table entry
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
        logic [7:0]  distance;
        logic [7:0]  nbrs;
        logic [7:0]  pstate;
        logic [7:0]  ptype;
    } entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PURGE_RD,
        ST_PURGE_CHK,
        ST_PURGE_MOVE,
        ST_STATS
    } state_t;

endpackage

// ----- sv/neighbor_table_with_aging_top.sv -----
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top
// update beat: accepted in idle, then a linear id search over the entries (a hit stops early), then stats
// purge beat: accepted in idle, then a read and a check per entry, plus a move per purged entry, then stats
// stats sweep: reads each entry left, then hands the result on once the output register is free
// one table read per cycle on the entry memory's read port
// one beat at a time; a finished result may wait in the output register meanwhile
// synchronous active-low reset clears count, sequencer, config registers and output valid, not the table
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ntwa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ntwa_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [31:0]                         s_now,
    input  logic [15:0]                         s_sender_id,
    input  logic [7:0]                          s_distance,
    input  logic [7:0]                          s_sender_neighbors,
    input  logic [7:0]                          s_sender_state,
    input  logic [7:0]                          s_sender_type,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [3:0]                          m_entry_count,
    output logic [6:0]                          m_nearest_distance,
    output logic [3:0]                          m_node_neighbors,
    output logic                                m_nest_near,
    output logic                                m_food_near,
    output logic                                m_was_dropped
);

    // table index width; the count never exceeds SLOTS-1 so it fits as well
    localparam int unsigned CW = $clog2(SLOTS);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] age_limit_reg,  age_limit_next;
    logic [7:0]  node_type_reg,  node_type_next;
    logic [15:0] nest_id_reg,    nest_id_next;
    logic [15:0] food_id_reg,    food_id_next;

    always_comb begin
        age_limit_next = age_limit_reg;
        node_type_next = node_type_reg;
        nest_id_next   = nest_id_reg;
        food_id_next   = food_id_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ntwa_pkg::CFG_AGE_LIMIT: age_limit_next = cfg_wdata[15:0];
                ntwa_pkg::CFG_NODE_TYPE: node_type_next = cfg_wdata[7:0];
                ntwa_pkg::CFG_NEST_ID:   nest_id_next   = cfg_wdata[15:0];
                ntwa_pkg::CFG_FOOD_ID:   food_id_next   = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= ntwa_pkg::AGE_LIMIT_RST;
            node_type_reg <= ntwa_pkg::NODE_TYPE_RST;
            nest_id_reg   <= ntwa_pkg::NEST_ID_RST;
            food_id_reg   <= ntwa_pkg::FOOD_ID_RST;
        end else begin
            age_limit_reg <= age_limit_next;
            node_type_reg <= node_type_next;
            nest_id_reg   <= nest_id_next;
            food_id_reg   <= food_id_next;
        end
    end

    // ------------------------------------------------------------------
    // entry table: one write and one registered read per cycle
    // entries at or above the count are never used, so no clearing
    // ------------------------------------------------------------------
    ntwa_pkg::entry_t table_mem [SLOTS];
    ntwa_pkg::entry_t rd_data_reg;
    logic [CW-1:0]    rd_addr;
    logic             mem_we;
    logic [CW-1:0]    mem_waddr;
    ntwa_pkg::entry_t mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    ntwa_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;     // valid entries
    logic [CW:0]      scan_reg,  scan_next;      // next address to read in a sweep
    logic             pend_reg,  pend_next;      // rd_data holds entry scan-1
    logic [CW:0]      k_reg,     k_next;         // purge walk: entries left to check
    ntwa_pkg::entry_t beat_reg,  beat_next;      // latched input beat

    // running statistics
    logic             dropped_reg, dropped_next;
    logic [6:0]       near_reg,    near_next;
    logic [CW-1:0]    nodes_reg,   nodes_next;
    logic             nest_reg,    nest_next;
    logic             food_reg,    food_next;

    // output register
    logic             m_valid_reg,     m_valid_next;
    logic [3:0]       m_count_reg,     m_count_next;
    logic [6:0]       m_near_reg,      m_near_next;
    logic [3:0]       m_nodes_reg,     m_nodes_next;
    logic             m_nest_reg,      m_nest_next;
    logic             m_food_reg,      m_food_next;
    logic             m_dropped_reg,   m_dropped_next;

    // helpers
    logic [CW:0]      scan_dec;
    logic [CW:0]      k_dec;
    logic [CW-1:0]    last_idx;
    logic [31:0]      age;
    logic             too_old;
    logic             out_free;
    logic [CW+3:0]    count_wide;
    logic [CW+3:0]    nodes_wide;

    assign scan_dec   = scan_reg - 1'b1;
    assign k_dec      = k_reg - 1'b1;
    assign last_idx   = count_reg - 1'b1;
    // subtract and compare for aging, modulo 2^32
    assign age        = beat_reg.stamp - rd_data_reg.stamp;
    assign too_old    = age > {16'd0, age_limit_reg};
    assign out_free   = !m_valid_reg || m_ready;
    assign count_wide = (CW + 4)'(count_reg);
    assign nodes_wide = (CW + 4)'(nodes_reg);

    assign s_ready = (state_reg == ntwa_pkg::ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        k_next         = k_reg;
        beat_next      = beat_reg;
        dropped_next   = dropped_reg;
        near_next      = near_reg;
        nodes_next     = nodes_reg;
        nest_next      = nest_reg;
        food_next      = food_reg;
        m_count_next   = m_count_reg;
        m_near_next    = m_near_reg;
        m_nodes_next   = m_nodes_reg;
        m_nest_next    = m_nest_reg;
        m_food_next    = m_food_reg;
        m_dropped_next = m_dropped_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        rd_addr        = scan_reg[CW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = count_reg;
        mem_wdata      = beat_reg;

        unique case (state_reg)
            ntwa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    beat_next.id       = s_sender_id;
                    beat_next.stamp    = s_now;
                    beat_next.distance = s_distance;
                    beat_next.nbrs     = s_sender_neighbors;
                    beat_next.pstate   = s_sender_state;
                    beat_next.ptype    = s_sender_type;
                    dropped_next       = 1'b0;
                    near_next          = ntwa_pkg::NEAREST_START;
                    nodes_next         = '0;
                    nest_next          = 1'b0;
                    food_next          = 1'b0;
                    scan_next          = '0;
                    pend_next          = 1'b0;
                    k_next             = {1'b0, count_reg};
                    if (!s_op) begin
                        state_next = ntwa_pkg::ST_SEARCH;
                    end else if (count_reg == '0) begin
                        state_next = ntwa_pkg::ST_STATS;
                    end else begin
                        state_next = ntwa_pkg::ST_PURGE_RD;
                    end
                end
            end

            // linear id search, one read issued per cycle
            ntwa_pkg::ST_SEARCH: begin
                if (pend_reg && (rd_data_reg.id == beat_reg.id)) begin
                    // hit: overwrite the matching entry
                    mem_we     = 1'b1;
                    mem_waddr  = scan_dec[CW-1:0];
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ntwa_pkg::ST_STATS;
                end else if (scan_reg == {1'b0, count_reg}) begin
                    // miss: append, or drop when the table is full
                    if (count_reg == FULL_COUNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ntwa_pkg::ST_STATS;
                end else begin
                    rd_addr   = scan_reg[CW-1:0];
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            // purge walk from the last entry down to the first
            ntwa_pkg::ST_PURGE_RD: begin
                rd_addr    = k_dec[CW-1:0];
                state_next = ntwa_pkg::ST_PURGE_CHK;
            end

            ntwa_pkg::ST_PURGE_CHK: begin
                if (too_old) begin
                    rd_addr    = last_idx;
                    state_next = ntwa_pkg::ST_PURGE_MOVE;
                end else begin
                    k_next = k_dec;
                    if (k_dec == '0) begin
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        state_next = ntwa_pkg::ST_STATS;
                    end else begin
                        state_next = ntwa_pkg::ST_PURGE_RD;
                    end
                end
            end

            // move the last entry into the purged slot
            ntwa_pkg::ST_PURGE_MOVE: begin
                mem_we     = 1'b1;
                mem_waddr  = k_dec[CW-1:0];
                mem_wdata  = rd_data_reg;
                count_next = last_idx;
                k_next     = k_dec;
                if (k_dec == '0) begin
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ntwa_pkg::ST_STATS;
                end else begin
                    state_next = ntwa_pkg::ST_PURGE_RD;
                end
            end

            // statistics sweep over all valid entries
            ntwa_pkg::ST_STATS: begin
                if (pend_reg) begin
                    if (rd_data_reg.distance < {1'b0, near_reg}) begin
                        near_next = rd_data_reg.distance[6:0];
                    end
                    if (rd_data_reg.ptype == node_type_reg) begin
                        nodes_next = nodes_reg + 1'b1;
                    end
                    if (rd_data_reg.id == nest_id_reg) begin
                        nest_next = 1'b1;
                    end
                    if (rd_data_reg.id == food_id_reg) begin
                        food_next = 1'b1;
                    end
                end
                if (scan_reg != {1'b0, count_reg}) begin
                    rd_addr   = scan_reg[CW-1:0];
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    // sweep done: hand the result to the output register
                    if (!pend_reg && out_free) begin
                        m_valid_next   = 1'b1;
                        m_count_next   = count_wide[3:0];
                        m_near_next    = near_reg;
                        m_nodes_next   = nodes_wide[3:0];
                        m_nest_next    = nest_reg;
                        m_food_next    = food_reg;
                        m_dropped_next = dropped_reg;
                        state_next     = ntwa_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ntwa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ntwa_pkg::ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            pend_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            pend_reg    <= pend_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        beat_reg      <= beat_next;
        dropped_reg   <= dropped_next;
        near_reg      <= near_next;
        nodes_reg     <= nodes_next;
        nest_reg      <= nest_next;
        food_reg      <= food_next;
        m_count_reg   <= m_count_next;
        m_near_reg    <= m_near_next;
        m_nodes_reg   <= m_nodes_next;
        m_nest_reg    <= m_nest_next;
        m_food_reg    <= m_food_next;
        m_dropped_reg <= m_dropped_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_entry_count      = m_count_reg;
    assign m_nearest_distance = m_near_reg;
    assign m_node_neighbors   = m_nodes_reg;
    assign m_nest_near        = m_nest_reg;
    assign m_food_near        = m_food_reg;
    assign m_was_dropped      = m_dropped_reg;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the neighbor table with aging
// A queue of message and purge beats feeds a clocked driver. The table and its
// statistics are predicted in the bench when each beat is accepted, and a
// clocked monitor checks every result beat against them. Both sides insert
// random gaps. The registers are rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SLOTS         = 16;
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no beat while work is open
    localparam int unsigned SETTLE_CYCLES = 100;   // longer than a full purge plus stats pass
    localparam int unsigned PHASE_ITEMS   = 165;

    // operation codes on s_op
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PURGE  = 1'b1;

    // one input beat
    typedef struct packed {
        logic        op;
        logic [31:0] now;
        logic [15:0] sender_id;
        logic [7:0]  distance;
        logic [7:0]  nbrs;
        logic [7:0]  pstate;
        logic [7:0]  ptype;
    } msg_t;

    // one result beat
    typedef struct packed {
        logic [3:0] count;
        logic [6:0] nearest;
        logic [3:0] nodes;
        logic       nest;
        logic       food;
        logic       dropped;
    } stats_t;

    // clock, reset and block ports
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [ntwa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ntwa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic        s_op               = OP_UPDATE;
    logic [31:0] s_now              = '0;
    logic [15:0] s_sender_id        = '0;
    logic [7:0]  s_distance         = '0;
    logic [7:0]  s_sender_neighbors = '0;
    logic [7:0]  s_sender_state     = '0;
    logic [7:0]  s_sender_type      = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_entry_count;
    logic [6:0]  m_nearest_distance;
    logic [3:0]  m_node_neighbors;
    logic        m_nest_near;
    logic        m_food_near;
    logic        m_was_dropped;

    // beats waiting to be driven, and statistics owed by the block
    msg_t   outgoing_msgs[$];
    stats_t stats_due[$];

    // bench copy of the registers
    logic [15:0] cfg_age  = ntwa_pkg::AGE_LIMIT_RST;
    logic [7:0]  cfg_node = ntwa_pkg::NODE_TYPE_RST;
    logic [15:0] cfg_nest = ntwa_pkg::NEST_ID_RST;
    logic [15:0] cfg_food = ntwa_pkg::FOOD_ID_RST;

    // bench copy of the table
    ntwa_pkg::entry_t shadow_tbl[SLOTS];
    int unsigned      shadow_cnt = 0;

    // gap state for both sides
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_calm = 0;
    int unsigned idle_cycles = 0;

    // run statistics
    int unsigned err_count  = 0;
    int unsigned n_checked  = 0;
    int unsigned n_upd      = 0;
    int unsigned n_hit      = 0;
    int unsigned n_drop     = 0;
    int unsigned n_purge    = 0;
    int unsigned n_aged     = 0;
    int unsigned peak_fill  = 0;

    neighbor_table_with_aging_top #(
        .SLOTS(SLOTS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_now              (s_now),
        .s_sender_id        (s_sender_id),
        .s_distance         (s_distance),
        .s_sender_neighbors (s_sender_neighbors),
        .s_sender_state     (s_sender_state),
        .s_sender_type      (s_sender_type),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_entry_count      (m_entry_count),
        .m_nearest_distance (m_nearest_distance),
        .m_node_neighbors   (m_node_neighbors),
        .m_nest_near        (m_nest_near),
        .m_food_near        (m_food_near),
        .m_was_dropped      (m_was_dropped)
    );

    always #4 aclk = ~aclk;

    // gap before the next beat, with occasional runs of back-to-back beats
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // applies one accepted beat to the bench table and returns the statistics
    function automatic stats_t apply_msg(msg_t m);
        stats_t      r;
        int unsigned pos;
        int unsigned nearest;
        int unsigned nodes;
        logic        hit;
        logic [31:0] age;
        r = '0;
        if (m.op == OP_UPDATE) begin
            n_upd++;
            hit = 1'b0;
            pos = shadow_cnt;
            for (int i = 0; i < shadow_cnt; i++) begin
                if (!hit && shadow_tbl[i].id == m.sender_id) begin
                    hit = 1'b1;
                    pos = i;
                end
            end
            if (!hit && shadow_cnt >= SLOTS - 1) begin
                // table full, new sender is lost
                r.dropped = 1'b1;
                n_drop++;
            end else begin
                if (hit)
                    n_hit++;
                else
                    shadow_cnt++;
                shadow_tbl[pos] = '{id: m.sender_id, stamp: m.now, distance: m.distance,
                                    nbrs: m.nbrs, pstate: m.pstate, ptype: m.ptype};
            end
        end else begin
            n_purge++;
            // walk down from the last entry, refill a hole from the current tail
            for (int k = shadow_cnt; k > 0; k--) begin
                age = m.now - shadow_tbl[k-1].stamp;
                if (age > {16'd0, cfg_age}) begin
                    shadow_tbl[k-1] = shadow_tbl[shadow_cnt-1];
                    shadow_cnt--;
                    n_aged++;
                end
            end
        end
        if (shadow_cnt > peak_fill)
            peak_fill = shadow_cnt;

        nearest = ntwa_pkg::NEAREST_START;
        nodes   = 0;
        for (int i = 0; i < shadow_cnt; i++) begin
            if (shadow_tbl[i].distance < nearest)
                nearest = shadow_tbl[i].distance;
            if (shadow_tbl[i].ptype == cfg_node)
                nodes++;
            if (shadow_tbl[i].id == cfg_nest)
                r.nest = 1'b1;
            if (shadow_tbl[i].id == cfg_food)
                r.food = 1'b1;
        end
        r.count   = shadow_cnt[3:0];
        r.nearest = nearest[6:0];
        r.nodes   = nodes[3:0];
        return r;
    endfunction

    function automatic void flag_error(string msg);
        if (err_count < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endfunction

    function automatic void queue_msg(logic op, logic [31:0] now, logic [15:0] id,
                                      logic [7:0] dist_in, logic [7:0] nbrs,
                                      logic [7:0] pst, logic [7:0] pty);
        outgoing_msgs.push_back('{op: op, now: now, sender_id: id, distance: dist_in,
                                  nbrs: nbrs, pstate: pst, ptype: pty});
    endfunction

    // ------------------------------------------------------------------------
    // driver: presents queued beats, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drv
        msg_t m;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                m = '{op: s_op, now: s_now, sender_id: s_sender_id, distance: s_distance,
                      nbrs: s_sender_neighbors, pstate: s_sender_state,
                      ptype: s_sender_type};
                stats_due.push_back(apply_msg(m));
            end
            // line is free after this edge, either empty or just accepted
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    s_valid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end else if (outgoing_msgs.size() != 0) begin
                    m = outgoing_msgs.pop_front();
                    s_op               <= m.op;
                    s_now              <= m.now;
                    s_sender_id        <= m.sender_id;
                    s_distance         <= m.distance;
                    s_sender_neighbors <= m.nbrs;
                    s_sender_state     <= m.pstate;
                    s_sender_type      <= m.ptype;
                    s_valid            <= 1'b1;
                    // gap that follows this beat once it is taken
                    tx_wait            <= draw_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: stalls the result side at random and checks each result beat
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : mon
        stats_t      got;
        stats_t      want;
        int unsigned d;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{count: m_entry_count, nearest: m_nearest_distance,
                        nodes: m_node_neighbors, nest: m_nest_near, food: m_food_near,
                        dropped: m_was_dropped};
                n_checked++;
                if (stats_due.size() == 0) begin
                    flag_error($sformatf("result beat with nothing pending: cnt=%0d near=%0d",
                                         got.count, got.nearest));
                end else begin
                    want = stats_due.pop_front();
                    if (got.count !== want.count || got.nearest !== want.nearest ||
                        got.nodes !== want.nodes || got.nest !== want.nest ||
                        got.food !== want.food || got.dropped !== want.dropped)
                        flag_error($sformatf({"stats mismatch: cnt/near/nodes/nest/food/drop",
                            " want %0d/%0d/%0d/%0b/%0b/%0b got %0d/%0d/%0d/%0b/%0b/%0b"},
                            want.count, want.nearest, want.nodes, want.nest, want.food,
                            want.dropped, got.count, got.nearest, got.nodes, got.nest,
                            got.food, got.dropped));
                end
                d = draw_gap(rx_calm);
                rx_wait <= d;
                m_ready <= (d == 0);
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= (rx_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no beat on either side for too long while work is open
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (outgoing_msgs.size() == 0 && !s_valid && stats_due.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d results owed",
                         idle_cycles, stats_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // register write through the plain write port
    task automatic write_reg(input logic [ntwa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ntwa_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ntwa_pkg::CFG_AGE_LIMIT: cfg_age  = data;
            ntwa_pkg::CFG_NODE_TYPE: cfg_node = data[7:0];
            ntwa_pkg::CFG_NEST_ID:   cfg_nest = data;
            ntwa_pkg::CFG_FOOD_ID:   cfg_food = data;
            default: ;
        endcase
    endtask

    // wait until every queued beat is sent and every result has come back
    task automatic wait_quiet();
        while (outgoing_msgs.size() != 0 || s_valid || stats_due.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] id_pool[24];
        logic [31:0] clk_now;
        logic [15:0] id;
        logic        op;
        int unsigned step_max;
        int unsigned r;

        // directed part, reset register values: age limit 64, node type 2,
        // nest id 0, food id 1
        queue_msg(OP_UPDATE, 32'd0,  16'h0000, 8'd0,   8'h00, 8'h00, 8'h00);  // nest
        queue_msg(OP_UPDATE, 32'd10, 16'h0001, 8'd255, 8'hFF, 8'hFF, 8'hFF);  // food
        queue_msg(OP_UPDATE, 32'd15, 16'hFFFF, 8'd89,  8'h5A, 8'hA5, 8'h02);
        queue_msg(OP_UPDATE, 32'd5,  16'h0000, 8'd90,  8'h01, 8'h02, 8'h02);  // hit
        // fill up to the last counted slot
        for (int k = 0; k < 12; k++)
            queue_msg(OP_UPDATE, 32'(20 + k), 16'(256 + k), 8'(100 + k), 8'(k), 8'(k),
                      (k % 2 == 0) ? 8'h02 : 8'h07);
        queue_msg(OP_UPDATE, 32'd40, 16'h1234, 8'd0, 8'h11, 8'h22, 8'h02);    // full, dropped
        queue_msg(OP_UPDATE, 32'd41, 16'h0001, 8'd3, 8'h33, 8'h44, 8'h02);    // hit while full
        // purge ignores the sender fields
        queue_msg(OP_PURGE, 32'd75, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // now below every stamp, so every age wraps huge
        queue_msg(OP_PURGE, 32'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_msg(OP_PURGE, 32'hFFFF_FFFF, 16'h5555, 8'hAA, 8'h55, 8'hAA, 8'h55);  // empty
        queue_msg(OP_UPDATE, 32'hFFFF_FFFF, 16'h0002, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // age exactly at the limit stays, one tick more goes
        queue_msg(OP_PURGE, 32'h0000_003F, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_msg(OP_PURGE, 32'h0000_0040, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_msg(OP_UPDATE, 32'h8000_0000, 16'h8000, 8'd1, 8'h80, 8'h80, 8'h80);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        clk_now = $urandom();
        for (int p = 0; p < 6; p++) begin
            // the first random phase runs on the reset values
            if (p != 0) begin
                wait_quiet();
                repeat (8) @(negedge aclk);
                case (p)
                    1: begin
                        write_reg(ntwa_pkg::CFG_AGE_LIMIT, 16'd0);
                        write_reg(ntwa_pkg::CFG_NODE_TYPE, 16'h0000);
                        write_reg(ntwa_pkg::CFG_NEST_ID,   16'hFFFF);
                        write_reg(ntwa_pkg::CFG_FOOD_ID,   16'hFFFF);
                    end
                    2: begin
                        write_reg(ntwa_pkg::CFG_AGE_LIMIT, 16'hFFFF);
                        write_reg(ntwa_pkg::CFG_NODE_TYPE, 16'h00FF);
                        write_reg(ntwa_pkg::CFG_NEST_ID,   16'h0000);
                        write_reg(ntwa_pkg::CFG_FOOD_ID,   16'h0000);
                    end
                    3: begin
                        // upper data bits set on the narrow register
                        write_reg(ntwa_pkg::CFG_AGE_LIMIT, 16'($urandom_range(1, 400)));
                        write_reg(ntwa_pkg::CFG_NODE_TYPE, 16'($urandom()));
                        write_reg(ntwa_pkg::CFG_NEST_ID,   16'($urandom()));
                        write_reg(ntwa_pkg::CFG_FOOD_ID,   16'($urandom()));
                    end
                    4: begin
                        write_reg(ntwa_pkg::CFG_AGE_LIMIT, 16'($urandom()));
                        write_reg(ntwa_pkg::CFG_NODE_TYPE, 16'($urandom_range(0, 255)));
                        write_reg(ntwa_pkg::CFG_NEST_ID,   16'($urandom()));
                        write_reg(ntwa_pkg::CFG_FOOD_ID,   16'($urandom()));
                    end
                    default: begin
                        write_reg(ntwa_pkg::CFG_AGE_LIMIT, 16'd64);
                        write_reg(ntwa_pkg::CFG_NODE_TYPE, 16'd2);
                        write_reg(ntwa_pkg::CFG_NEST_ID,   16'd0);
                        write_reg(ntwa_pkg::CFG_FOOD_ID,   16'd1);
                    end
                endcase
            end

            // a pool a bit larger than the table gives hits, fills and drops
            id_pool[0] = cfg_nest;
            id_pool[1] = cfg_food;
            for (int k = 2; k < 24; k++)
                id_pool[k] = 16'($urandom());
            step_max = cfg_age / 6 + 2;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < 18) ? OP_PURGE : OP_UPDATE;
                r  = $urandom_range(0, 99);
                if (r < 3)
                    clk_now = $urandom();                          // wild jump
                else if (r < 6)
                    clk_now = clk_now - $urandom_range(1, step_max);  // clock steps back
                else
                    clk_now = clk_now + $urandom_range(0, step_max);
                // some purges land right around the age limit
                if (op == OP_PURGE && $urandom_range(0, 3) == 0)
                    clk_now = clk_now + cfg_age + $urandom_range(0, 2);
                id = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                 : id_pool[$urandom_range(0, 23)];
                queue_msg(op, clk_now, id,
                          $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 95)),
                          8'($urandom()), 8'($urandom()),
                          ($urandom_range(0, 2) == 0) ? cfg_node : 8'($urandom()));
            end
        end

        wait_quiet();
        // anything arriving now is a stray result
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (stats_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", stats_due.size()));

        $display("covered %0d updates (%0d hits, %0d drops on a full table), %0d purges",
                 n_upd, n_hit, n_drop, n_purge);
        $display("%0d entries aged out, peak fill %0d, %0d results checked, %0d errors",
                 n_aged, peak_fill, n_checked, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
